FILE: hw/rtl/prs_pkg.sv
// Shared types, constants and helpers for the pulse rate smoother.
// No dependencies; imported by every module of the block.
package prs_pkg;

  // Default width of the external pulse counter
  localparam int COUNTER_BITS_DEF = 16;

  // Field and state widths
  localparam int RAW_W    = 16;
  localparam int ELAP_W   = 20;
  localparam int PULSE_W  = 24;
  localparam int TIME_W   = 32;
  localparam int RATE_W   = 48;
  localparam int PUB_W    = 32;
  localparam int LVL_W    = 16;
  localparam int WIN_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Stream payload widths (whole bytes)
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WARN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DANGER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLICK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 3'd4;

  // Register reset values
  localparam logic [LVL_W-1:0] WARN_RST   = 16'd100;
  localparam logic [LVL_W-1:0] DANGER_RST = 16'd1000;
  localparam logic [WIN_W-1:0] WINDOW_RST = 8'd50;

  // Blink colors
  localparam logic [1:0] BLINK_NONE   = 2'd0;
  localparam logic [1:0] BLINK_GREEN  = 2'd1;
  localparam logic [1:0] BLINK_YELLOW = 2'd2;
  localparam logic [1:0] BLINK_RED    = 2'd3;

  // Arithmetic constants
  localparam logic [25:0]       US_PER_MIN = 26'd60000000;
  localparam logic [PULSE_W-1:0] PULSE_MAX = '1;
  localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
  localparam logic [RATE_W-1:0]  RATE_MAX  = '1;

  // Smoothing tiers: Q32.16 bounds and Q0.16 alphas
  localparam logic [RATE_W-1:0] TIER_LO_BND  = 48'd40 << 16;
  localparam logic [RATE_W-1:0] TIER_MID_BND = 48'd200 << 16;
  localparam logic [RATE_W-1:0] TIER_HI_BND  = 48'd1000 << 16;
  localparam logic [15:0] ALPHA_LO   = 16'd2621;
  localparam logic [15:0] ALPHA_MID  = 16'd7864;
  localparam logic [15:0] ALPHA_HI   = 16'd13107;
  localparam logic [15:0] ALPHA_FAST = 16'd45875;

  // Request into the rate unit
  typedef struct packed {
    logic                start;
    logic [PULSE_W-1:0]  pulses;
    logic [TIME_W-1:0]   time_us;
    logic [RATE_W-1:0]   smoothed;
  } prs_req_t;

  // Result from the rate unit
  typedef struct packed {
    logic                done;
    logic [RATE_W-1:0]   smoothed;
    logic [PUB_W-1:0]    pub;
  } prs_res_t;

  // Pick the smoothing weight from the current smoothed rate
  function automatic logic [15:0] pick_alpha(input logic [RATE_W-1:0] s);
    logic [15:0] a;
    if (s < TIER_LO_BND) a = ALPHA_LO;
    else if (s < TIER_MID_BND) a = ALPHA_MID;
    else if (s < TIER_HI_BND) a = ALPHA_HI;
    else a = ALPHA_FAST;
    return a;
  endfunction

endpackage

FILE: hw/rtl/prs_rate_unit.sv
// Window close arithmetic: rate = pulses*60e6/time, blend, publish x100.
// One shared adder/subtractor under a one-hot sequencer. Depends on prs_pkg.
module prs_rate_unit
  import prs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  prs_req_t req,
  output prs_res_t res
);

  localparam int ADD_W     = 56;
  localparam int DIV_STEPS = 48;
  localparam int MUL_STEPS = 16;
  localparam int CNT_W     = 6;

  typedef enum logic [9:0] {
    U_IDLE = 10'b0000000001,
    U_MUL  = 10'b0000000010,
    U_CHK  = 10'b0000000100,
    U_DIV  = 10'b0000001000,
    U_DIFF = 10'b0000010000,
    U_NEG  = 10'b0000100000,
    U_AMUL = 10'b0001000000,
    U_UPD  = 10'b0010000000,
    U_PUB1 = 10'b0100000000,
    U_PUB2 = 10'b1000000000
  } ustate_t;

  ustate_t            st_r, st_nxt;
  logic [PULSE_W-1:0] pulses_r, pulses_nxt;
  logic [TIME_W-1:0]  time_r, time_nxt;
  logic [RATE_W-1:0]  s_r, s_nxt;
  logic [15:0]        alpha_r, alpha_nxt;
  logic [49:0]        num_r, num_nxt;
  logic [31:0]        rem_r, rem_nxt;
  logic [RATE_W-1:0]  dvd_r, dvd_nxt;
  logic [RATE_W-1:0]  diff_r, diff_nxt;
  logic               neg_r, neg_nxt;
  logic [63:0]        prod_r, prod_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ADD_W-1:0]   t_r, t_nxt;
  logic [PUB_W-1:0]   pub_r, pub_nxt;
  logic               done_r, done_nxt;

  // Shared adder/subtractor
  logic [ADD_W-1:0] add_a, add_b, add_y;
  logic             add_sub;
  logic [32:0]      shifted;
  logic             qbit;
  logic [48:0]      mul_hi;

  assign add_y = add_a + (add_sub ? ~add_b : add_b) + ADD_W'(add_sub);
  assign shifted = {rem_r, dvd_r[RATE_W-1]};
  assign qbit = ~add_y[ADD_W-1];
  assign mul_hi = prod_r[0] ? add_y[48:0] : {1'b0, prod_r[63:16]};

  // Route operands to the shared adder
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (st_r)
      U_DIV: begin
        add_a   = ADD_W'(shifted);
        add_b   = ADD_W'(time_r);
        add_sub = 1'b1;
      end
      U_DIFF: begin
        add_a   = ADD_W'(dvd_r);
        add_b   = ADD_W'(s_r);
        add_sub = 1'b1;
      end
      U_NEG: begin
        add_a   = ADD_W'(s_r);
        add_b   = ADD_W'(dvd_r);
        add_sub = 1'b1;
      end
      U_AMUL: begin
        add_a = ADD_W'(prod_r[63:16]);
        add_b = ADD_W'(diff_r);
      end
      U_UPD: begin
        add_a   = ADD_W'(s_r);
        add_b   = ADD_W'(prod_r[63:16]);
        add_sub = neg_r;
      end
      U_PUB1: begin
        add_a = ADD_W'({s_r, 6'b0});
        add_b = ADD_W'({s_r, 5'b0});
      end
      U_PUB2: begin
        add_a = t_r;
        add_b = ADD_W'({s_r, 2'b0});
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    st_nxt     = st_r;
    pulses_nxt = pulses_r;
    time_nxt   = time_r;
    s_nxt      = s_r;
    alpha_nxt  = alpha_r;
    num_nxt    = num_r;
    rem_nxt    = rem_r;
    dvd_nxt    = dvd_r;
    diff_nxt   = diff_r;
    neg_nxt    = neg_r;
    prod_nxt   = prod_r;
    cnt_nxt    = cnt_r;
    t_nxt      = t_r;
    pub_nxt    = pub_r;
    done_nxt   = 1'b0;
    unique case (st_r)
      U_IDLE: begin
        if (req.start) begin
          pulses_nxt = req.pulses;
          time_nxt   = req.time_us;
          s_nxt      = req.smoothed;
          alpha_nxt  = pick_alpha(req.smoothed);
          st_nxt     = U_MUL;
        end
      end
      U_MUL: begin
        num_nxt = 50'(pulses_r) * 50'(US_PER_MIN);
        st_nxt  = U_CHK;
      end
      U_CHK: begin
        // Zero time, or a quotient that reaches 2^32, skips the divide
        cnt_nxt = '0;
        if (time_r == '0) begin
          dvd_nxt = (pulses_r == '0) ? '0 : RATE_MAX;
          st_nxt  = U_DIFF;
        end else if (32'(num_r[49:32]) >= time_r) begin
          dvd_nxt = RATE_MAX;
          st_nxt  = U_DIFF;
        end else begin
          rem_nxt = 32'(num_r[49:32]);
          dvd_nxt = {num_r[31:0], 16'b0};
          st_nxt  = U_DIV;
        end
      end
      U_DIV: begin
        // One restoring step; quotient bits shift in behind the dividend
        rem_nxt = qbit ? add_y[31:0] : shifted[31:0];
        dvd_nxt = {dvd_r[RATE_W-2:0], qbit};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) st_nxt = U_DIFF;
      end
      U_DIFF: begin
        prod_nxt = {48'b0, alpha_r};
        cnt_nxt  = '0;
        if (add_y[ADD_W-1]) begin
          neg_nxt = 1'b1;
          st_nxt  = U_NEG;
        end else begin
          neg_nxt  = 1'b0;
          diff_nxt = add_y[RATE_W-1:0];
          st_nxt   = U_AMUL;
        end
      end
      U_NEG: begin
        diff_nxt = add_y[RATE_W-1:0];
        st_nxt   = U_AMUL;
      end
      U_AMUL: begin
        // Shift-add multiply by alpha, LSB first
        prod_nxt = {mul_hi, prod_r[15:1]};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MUL_STEPS - 1)) st_nxt = U_UPD;
      end
      U_UPD: begin
        s_nxt  = add_y[RATE_W-1:0];
        st_nxt = U_PUB1;
      end
      U_PUB1: begin
        t_nxt  = add_y;
        st_nxt = U_PUB2;
      end
      U_PUB2: begin
        // Drop 16 fraction bits, saturate to 32 bits
        pub_nxt  = (|add_y[54:48]) ? '1 : add_y[47:16];
        done_nxt = 1'b1;
        st_nxt   = U_IDLE;
      end
      default: begin
        st_nxt = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= U_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    pulses_r <= pulses_nxt;
    time_r   <= time_nxt;
    s_r      <= s_nxt;
    alpha_r  <= alpha_nxt;
    num_r    <= num_nxt;
    rem_r    <= rem_nxt;
    dvd_r    <= dvd_nxt;
    diff_r   <= diff_nxt;
    neg_r    <= neg_nxt;
    prod_r   <= prod_nxt;
    cnt_r    <= cnt_nxt;
    t_r      <= t_nxt;
    pub_r    <= pub_nxt;
  end

  assign res.done     = done_r;
  assign res.smoothed = s_r;
  assign res.pub      = pub_r;

endmodule

FILE: hw/rtl/pulse_rate_smoother.sv
// Top level of the pulse rate smoother: tick accumulation, blink and click,
// output register and handshake. Depends on prs_pkg and prs_rate_unit.
//
// Usage:
//   The in_ channel carries one tick per transaction: the pulse counter
//   value and the microseconds since the previous tick. The out_ channel
//   returns exactly one result per tick: click, blink color, a flag that
//   marks a window close, and the smoothed rate in counts per minute x100.
//   The cfg_ port writes thresholds, enables and the window length; the
//   user must write them only while the block is idle, as the block itself
//   does not enforce this. A tick that does not close a window goes to
//   ST_HOLD, which loads its result into the output register once that is
//   free and returns to ST_IDLE. A window close waits in ST_BUSY while the
//   rate unit runs the 48-step restoring divide (skipped on zero time or
//   saturation) and the 16-step multiply on its shared adder.
//   in_tready is high only while no tick is being worked on; a result that
//   waits in the output register does not hold off the next tick, but a
//   second result waits until out_tready takes the first.
//   Reset (rst_n low at a clock edge) restores the register defaults,
//   clears all window and smoothing state and empties the output.
module pulse_rate_smoother
  import prs_pkg::*;
#(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [15:0] raw_count (signed), [35:16] elapsed_us, [39:36] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] click, [2:1] blink_color, [3] rate_valid, [35:4] rate_x100,
  // [39:36] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_data
);

  localparam int EXT_W = (COUNTER_BITS > RAW_W) ? COUNTER_BITS : RAW_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_BUSY = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t             st_r, st_nxt;
  logic [LVL_W-1:0]   warn_r, danger_r;
  logic               click_en_r, blink_en_r;
  logic [WIN_W-1:0]   window_r;
  logic [RAW_W-1:0]   prev_r, prev_nxt;
  logic [WIN_W-1:0]   tick_r, tick_nxt;
  logic [PULSE_W-1:0] pulses_r, pulses_nxt;
  logic [TIME_W-1:0]  time_r, time_nxt;
  logic [RATE_W-1:0]  smooth_r, smooth_nxt;
  logic [PUB_W-1:0]   pub_r, pub_nxt;
  logic               res_click_r, res_click_nxt;
  logic [1:0]         res_color_r, res_color_nxt;
  logic               res_valid_r, res_valid_nxt;
  logic [PUB_W-1:0]   res_rate_r, res_rate_nxt;
  logic               start_r, start_nxt;
  logic [PULSE_W-1:0] rq_pulses_r, rq_pulses_nxt;
  logic [TIME_W-1:0]  rq_time_r, rq_time_nxt;
  logic               out_v_r, out_v_nxt;
  logic [OUT_DATA_W-1:0] out_d_r, out_d_nxt;

  logic                    in_acc;
  logic                    out_free;
  logic signed [RAW_W-1:0] raw_s;
  logic [EXT_W-1:0]        raw_ext, prev_ext, cur_ext;
  logic [COUNTER_BITS-1:0] cur, delta;
  logic [32:0]             psum, tsum;
  logic [PULSE_W-1:0]      p_new;
  logic [TIME_W-1:0]       t_new;
  logic [WIN_W-1:0]        tick_inc;
  logic                    closing;
  logic [1:0]              color;
  prs_req_t                req;
  prs_res_t                res;

  assign in_tready = (st_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_v_r || out_tready;

  // Wrapped counter difference modulo 2^COUNTER_BITS
  assign raw_s    = signed'(in_tdata[RAW_W-1:0]);
  assign raw_ext  = EXT_W'(raw_s);
  assign prev_ext = EXT_W'(prev_r);
  assign cur      = raw_ext[COUNTER_BITS-1:0];
  assign delta    = cur - prev_ext[COUNTER_BITS-1:0];
  assign cur_ext  = EXT_W'(cur);

  // Saturating window totals
  assign psum  = 33'(pulses_r) + 33'(delta);
  assign p_new = (psum > 33'(PULSE_MAX)) ? PULSE_MAX : psum[PULSE_W-1:0];
  assign tsum  = 33'(time_r) + 33'(in_tdata[RAW_W +: ELAP_W]);
  assign t_new = tsum[32] ? TIME_MAX : tsum[TIME_W-1:0];

  assign tick_inc = tick_r + 1'b1;
  assign closing  = (tick_inc >= window_r);

  // Blink color from the smoothed rate before this tick
  always_comb begin
    priority if (!blink_en_r || delta == '0) color = BLINK_NONE;
    else if (smooth_r >= {danger_r, 16'b0}) color = BLINK_RED;
    else if (smooth_r >= {warn_r, 16'b0}) color = BLINK_YELLOW;
    else color = BLINK_GREEN;
  end

  // Tick handling and result sequencing
  always_comb begin
    st_nxt        = st_r;
    prev_nxt      = prev_r;
    tick_nxt      = tick_r;
    pulses_nxt    = pulses_r;
    time_nxt      = time_r;
    smooth_nxt    = smooth_r;
    pub_nxt       = pub_r;
    res_click_nxt = res_click_r;
    res_color_nxt = res_color_r;
    res_valid_nxt = res_valid_r;
    res_rate_nxt  = res_rate_r;
    start_nxt     = 1'b0;
    rq_pulses_nxt = rq_pulses_r;
    rq_time_nxt   = rq_time_r;
    out_v_nxt     = out_v_r && !out_tready;
    out_d_nxt     = out_d_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          prev_nxt      = cur_ext[RAW_W-1:0];
          res_click_nxt = click_en_r && (delta != '0);
          res_color_nxt = color;
          res_rate_nxt  = pub_r;
          if (closing) begin
            rq_pulses_nxt = p_new;
            rq_time_nxt   = t_new;
            start_nxt     = 1'b1;
            pulses_nxt    = '0;
            time_nxt      = '0;
            tick_nxt      = '0;
            res_valid_nxt = 1'b1;
            st_nxt        = ST_BUSY;
          end else begin
            pulses_nxt    = p_new;
            time_nxt      = t_new;
            tick_nxt      = tick_inc;
            res_valid_nxt = 1'b0;
            st_nxt        = ST_HOLD;
          end
        end
      end
      ST_BUSY: begin
        if (res.done) begin
          smooth_nxt   = res.smoothed;
          pub_nxt      = res.pub;
          res_rate_nxt = res.pub;
          st_nxt       = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_v_nxt = 1'b1;
          out_d_nxt = OUT_DATA_W'({res_rate_r, res_valid_r, res_color_r, res_click_r});
          st_nxt    = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warn_r     <= WARN_RST;
      danger_r   <= DANGER_RST;
      click_en_r <= 1'b1;
      blink_en_r <= 1'b1;
      window_r   <= WINDOW_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_WARN:   warn_r     <= cfg_data;
        REG_DANGER: danger_r   <= cfg_data;
        REG_CLICK:  click_en_r <= cfg_data[0];
        REG_BLINK:  blink_en_r <= cfg_data[0];
        REG_WINDOW: window_r   <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // State and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      prev_r   <= '0;
      tick_r   <= '0;
      pulses_r <= '0;
      time_r   <= '0;
      smooth_r <= '0;
      pub_r    <= '0;
      start_r  <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      prev_r   <= prev_nxt;
      tick_r   <= tick_nxt;
      pulses_r <= pulses_nxt;
      time_r   <= time_nxt;
      smooth_r <= smooth_nxt;
      pub_r    <= pub_nxt;
      start_r  <= start_nxt;
      out_v_r  <= out_v_nxt;
    end
    res_click_r <= res_click_nxt;
    res_color_r <= res_color_nxt;
    res_valid_r <= res_valid_nxt;
    res_rate_r  <= res_rate_nxt;
    rq_pulses_r <= rq_pulses_nxt;
    rq_time_r   <= rq_time_nxt;
    out_d_r     <= out_d_nxt;
  end

  assign req.start    = start_r;
  assign req.pulses   = rq_pulses_r;
  assign req.time_us  = rq_time_r;
  assign req.smoothed = smooth_r;

  prs_rate_unit u_rate (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .res   (res)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

endmodule

FILE: hw/rtl/prs_checker.sv
// Port-level checks for the pulse rate smoother, bound to the top level.
// Depends on prs_pkg and on the ports of pulse_rate_smoother.
module prs_checker
  import prs_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // A tick keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted on back-to-back cycles");

  // Reset empties the output and leaves the block ready
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("state not cleared by reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled output changed");

  // Padding above the result fields stays zero
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_DATA_W-1:36] == '0))
    else $error("output padding bits not zero");

endmodule

bind pulse_rate_smoother prs_checker u_prs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
